>>> rtl/tmsc_pkg.sv
// shared types and constants of the trimmed-mean sensor calibrator
package tmsc_pkg;

  // samples per batch and trim shift (eight middle samples)
  localparam int unsigned BATCH_LEN  = 10;
  localparam int unsigned TRIM_SHIFT = 3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 3'd5;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned ZERO_W     = 12;

  typedef enum logic [1:0] {
    MODE_LOOP   = 2'd0,
    MODE_LINEAR = 2'd1,
    MODE_DOUBLE = 2'd2
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [ZERO_W-1:0]  zero_count;
    logic signed [31:0] gain;
    logic signed [31:0] offset;
    logic signed [31:0] low_limit;
    logic signed [31:0] high_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    mode:       MODE_LINEAR,
    zero_count: '0,
    gain:       32'sd65536,
    offset:     '0,
    low_limit:  '0,
    high_limit: 32'sh7fff_ffff
  };

endpackage

>>> rtl/tmsc_stats.sv
// running sum, maximum, minimum and count of one batch, with the batch register
module tmsc_stats #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   batch_valid_o,
  input  logic                   batch_ready_i,
  output logic [SAMPLE_BITS+3:0] batch_sum_o,
  output logic [SAMPLE_BITS-1:0] batch_max_o,
  output logic [SAMPLE_BITS-1:0] batch_min_o
);

  localparam int unsigned SumW = SAMPLE_BITS + 4;
  localparam int unsigned CntW = $clog2(tmsc_pkg::BATCH_LEN);

  logic [CntW-1:0]        count_q, count_d;
  logic [SumW-1:0]        sum_q, sum_d;
  logic [SAMPLE_BITS-1:0] max_q, max_d, min_q, min_d;
  logic                   b_valid_q;
  logic [SumW-1:0]        b_sum_q;
  logic [SAMPLE_BITS-1:0] b_max_q, b_min_q;
  logic                   accept, last, first;

  assign last       = (count_q == CntW'(tmsc_pkg::BATCH_LEN - 1));
  assign first      = (count_q == '0);
  // only the closing sample of a batch needs room downstream
  assign in_stall_o = last && b_valid_q && !batch_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (first) begin
      sum_d = SumW'(sample_i);
      max_d = sample_i;
      min_d = sample_i;
    end else begin
      sum_d = sum_q + SumW'(sample_i);
      max_d = (sample_i > max_q) ? sample_i : max_q;
      min_d = (sample_i < min_q) ? sample_i : min_q;
    end
    count_d = last ? '0 : count_q + CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      b_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept && last) begin
        b_valid_q <= 1'b1;
      end else if (batch_ready_i) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sum_q <= sum_d;
      max_q <= max_d;
      min_q <= min_d;
    end
    if (accept && last) begin
      b_sum_q <= sum_d;
      b_max_q <= max_d;
      b_min_q <= min_d;
    end
  end

  assign batch_valid_o = b_valid_q;
  assign batch_sum_o   = b_sum_q;
  assign batch_max_o   = b_max_q;
  assign batch_min_o   = b_min_q;

endmodule

>>> rtl/tmsc_calib.sv
// trimmed average and calibration pipeline with output register
module tmsc_calib #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tmsc_pkg::cfg_t         cfg_i,
  input  logic                   batch_valid_i,
  output logic                   batch_ready_o,
  input  logic [SAMPLE_BITS+3:0] batch_sum_i,
  input  logic [SAMPLE_BITS-1:0] batch_max_i,
  input  logic [SAMPLE_BITS-1:0] batch_min_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SAMPLE_BITS-1:0] average_o,
  output logic signed [31:0]     value_o,
  output logic                   clipped_o
);

  localparam int unsigned SumW = SAMPLE_BITS + 4;
  localparam int unsigned CmpW = (SAMPLE_BITS > tmsc_pkg::ZERO_W) ? SAMPLE_BITS
                                                                  : tmsc_pkg::ZERO_W;
  localparam int unsigned PW   = 32 + CmpW + 1;
  localparam int unsigned EW   = PW + 2;

  logic v_b_q, v_c_q, v_d_q, v_e_q;
  logic rdy_b, rdy_c, rdy_d, rdy_e;

  logic [SumW-1:0]        diff;
  logic [SAMPLE_BITS-1:0] avg_d;
  logic [CmpW-1:0]        oper_d;
  logic [SAMPLE_BITS-1:0] avg_b_q, avg_c_q, avg_d_q, avg_e_q;
  logic [CmpW-1:0]        oper_b_q;
  logic signed [PW-1:0]   prod_d, prod_c_q;
  logic signed [EW-1:0]   prod_ext, offs_ext, low_ext, exact_d, exact_d_q;
  logic signed [EW-1:0]   high_ext, min_ext;
  logic signed [31:0]     value_d, value_e_q;
  logic                   clip_d, clip_e_q;

  // per-stage ready: a stage takes a beat when empty or when it drains
  assign rdy_e         = !v_e_q || !out_stall_i;
  assign rdy_d         = !v_d_q || rdy_e;
  assign rdy_c         = !v_c_q || rdy_d;
  assign rdy_b         = !v_b_q || rdy_c;
  assign batch_ready_o = rdy_b;

  // stage b: trimmed average and mode 0 clamp
  always_comb begin
    diff   = batch_sum_i - SumW'(batch_max_i) - SumW'(batch_min_i);
    avg_d  = diff[tmsc_pkg::TRIM_SHIFT +: SAMPLE_BITS];
    oper_d = CmpW'(avg_d);
    if (cfg_i.mode == tmsc_pkg::MODE_LOOP && CmpW'(avg_d) < CmpW'(cfg_i.zero_count)) begin
      oper_d = CmpW'(cfg_i.zero_count);
    end
  end

  // stage c: gain product
  assign prod_d = PW'($signed(cfg_i.gain)) * PW'($signed({1'b0, oper_b_q}));

  // stage d: offset or low limit
  always_comb begin
    prod_ext = {{2{prod_c_q[PW-1]}}, prod_c_q};
    offs_ext = {{(EW-32){cfg_i.offset[31]}}, cfg_i.offset};
    low_ext  = {{(EW-32){cfg_i.low_limit[31]}}, cfg_i.low_limit};
    unique case (cfg_i.mode)
      tmsc_pkg::MODE_LOOP:   exact_d = prod_ext - offs_ext;
      tmsc_pkg::MODE_DOUBLE: exact_d = (prod_ext <<< 1) + low_ext;
      default:               exact_d = prod_ext + low_ext;
    endcase
  end

  // stage e: clip to high limit, saturate below
  always_comb begin
    high_ext = {{(EW-32){cfg_i.high_limit[31]}}, cfg_i.high_limit};
    min_ext  = {{(EW-31){1'b1}}, 31'b0};
    clip_d   = 1'b0;
    if (exact_d_q > high_ext) begin
      value_d = cfg_i.high_limit;
      clip_d  = 1'b1;
    end else if (exact_d_q < min_ext) begin
      value_d = 32'sh8000_0000;
    end else begin
      value_d = exact_d_q[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
      v_d_q <= 1'b0;
      v_e_q <= 1'b0;
    end else begin
      if (rdy_b) v_b_q <= batch_valid_i;
      if (rdy_c) v_c_q <= v_b_q;
      if (rdy_d) v_d_q <= v_c_q;
      if (rdy_e) v_e_q <= v_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && batch_valid_i) begin
      avg_b_q  <= avg_d;
      oper_b_q <= oper_d;
    end
    if (rdy_c && v_b_q) begin
      avg_c_q  <= avg_b_q;
      prod_c_q <= prod_d;
    end
    if (rdy_d && v_c_q) begin
      avg_d_q   <= avg_c_q;
      exact_d_q <= exact_d;
    end
    if (rdy_e && v_d_q) begin
      avg_e_q   <= avg_d_q;
      value_e_q <= value_d;
      clip_e_q  <= clip_d;
    end
  end

  assign out_valid_o = v_e_q;
  assign average_o   = avg_e_q;
  assign value_o     = value_e_q;
  assign clipped_o   = clip_e_q;

endmodule

>>> rtl/trimmed_mean_sensor_calibrator_core.sv
// top level of the trimmed-mean sensor calibrator for one converter channel
//
// One converter channel per instance. The block takes one sample beat per clock
// and folds it into a running sum, maximum and minimum. Every tenth sample closes a
// batch: the average of the eight middle samples, (sum - max - min) >> 3, is formed
// and calibrated into a signed Q16.16 value (mode 0: gain * max(avg, zero_count) -
// offset; mode 1 and the unused code 3: gain * avg + low_limit; mode 2:
// 2 * gain * avg + low_limit). A value above high_limit is replaced by high_limit
// and flagged on clipped_o; a value below the 32-bit range saturates to -2^31.
// Rate: one sample per cycle while in_stall_o is low; sum, max and min are
// registered as each sample is taken. A result beat passes from the batch register,
// which loads on the edge that takes the tenth sample, through the trim, multiply
// and add stages and the clip/output register; the result pipeline holds up to five
// batches, so in_stall_o rises only on the closing sample of a batch while all of
// them wait behind a stalled output. The user must write configuration through
// cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle; the block does not
// enforce it. Indexes beyond high_limit are ignored. There is no clearing pass.
module trimmed_mean_sensor_calibrator_core #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [tmsc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tmsc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // sample channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [SAMPLE_BITS-1:0]              sample_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [SAMPLE_BITS-1:0]              average_o,
  output logic signed [31:0]                  value_o,
  output logic                                clipped_o
);

  tmsc_pkg::cfg_t cfg_q;

  logic                   batch_valid, batch_ready;
  logic [SAMPLE_BITS+3:0] batch_sum;
  logic [SAMPLE_BITS-1:0] batch_max, batch_min;

  // register file: plain indexed writes, out-of-range indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= tmsc_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tmsc_pkg::REG_MODE:       cfg_q.mode       <= tmsc_pkg::mode_e'(cfg_data_i[1:0]);
        tmsc_pkg::REG_ZERO_COUNT: cfg_q.zero_count <= cfg_data_i[tmsc_pkg::ZERO_W-1:0];
        tmsc_pkg::REG_GAIN:       cfg_q.gain       <= $signed(cfg_data_i);
        tmsc_pkg::REG_OFFSET:     cfg_q.offset     <= $signed(cfg_data_i);
        tmsc_pkg::REG_LOW_LIMIT:  cfg_q.low_limit  <= $signed(cfg_data_i);
        tmsc_pkg::REG_HIGH_LIMIT: cfg_q.high_limit <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // batch statistics, one sample beat per cycle unless in_stall_o is raised
  tmsc_stats #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_stats (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .batch_valid_o(batch_valid),
    .batch_ready_i(batch_ready),
    .batch_sum_o  (batch_sum),
    .batch_max_o  (batch_max),
    .batch_min_o  (batch_min)
  );

  // trimmed average and calibration, ending in the output register
  tmsc_calib #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_calib (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .batch_valid_i(batch_valid),
    .batch_ready_o(batch_ready),
    .batch_sum_i  (batch_sum),
    .batch_max_i  (batch_max),
    .batch_min_i  (batch_min),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .average_o    (average_o),
    .value_o      (value_o),
    .clipped_o    (clipped_o)
  );

endmodule

>>> rtl/tmsc_checker.sv
// port-level checks of the calibrator core and their bind
module tmsc_checker #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [SAMPLE_BITS-1:0] average_o,
  input logic signed [31:0]     value_o,
  input logic                   clipped_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(average_o)
      && $stable(value_o) && $stable(clipped_o))
    else $error("result beat changed while stalled");

  // input backpressure only when the output itself is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // the pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("pipeline not empty after reset");

endmodule

bind trimmed_mean_sensor_calibrator_core tmsc_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_tmsc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .average_o  (average_o),
  .value_o    (value_o),
  .clipped_o  (clipped_o)
);

>>> verif/tb_trimmed_mean_sensor_calibrator_core.sv
// testbench of the trimmed-mean sensor calibrator core, self-checking against a batch predictor
module tb_trimmed_mean_sensor_calibrator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SAMPLE_BITS  = 12;
  localparam int unsigned MAX_SAMPLE   = (1 << SAMPLE_BITS) - 1;
  // indexes past high_limit, writes there must leave every register alone
  localparam logic [tmsc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [tmsc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  // mode code with no meaning of its own, behaves as linear
  localparam logic [1:0] MODE_SPARE   = 2'd3;
  // five-stage result pipe plus margin
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TIMEOUT_NS   = 2_000_000;
  localparam longint      VALUE_MIN    = -64'sd2147483648;

  typedef struct {
    logic [SAMPLE_BITS-1:0] average;
    logic signed [31:0]     value;
    logic                   clipped;
  } batch_result_t;

  // how the samples of one burst are spread
  typedef enum int unsigned {
    STYLE_SPREAD,
    STYLE_NOISY,
    STYLE_RAIL,
    STYLE_FLAT
  } sample_style_e;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_we;
  logic [tmsc_pkg::CFG_IDX_W-1:0]    cfg_idx;
  logic [tmsc_pkg::CFG_DATA_W-1:0]   cfg_data;
  logic                              in_valid;
  logic                              in_stall;
  logic [SAMPLE_BITS-1:0]            sample;
  logic                              out_valid;
  logic                              out_stall;
  logic [SAMPLE_BITS-1:0]            average;
  logic signed [31:0]                value;
  logic                              clipped;

  // predictor copy of the settings
  logic [1:0]                        cal_mode;
  logic [tmsc_pkg::ZERO_W-1:0]       cal_zero;
  longint                            cal_gain;
  longint                            cal_offset;
  longint                            cal_low;
  longint                            cal_high;

  // predictor copy of the batch accumulator
  int unsigned            batch_fill;
  int unsigned            batch_sum;
  logic [SAMPLE_BITS-1:0] batch_max;
  logic [SAMPLE_BITS-1:0] batch_min;

  // calibrated results still owed by the block, oldest first
  batch_result_t          batch_results_q[$];
  int unsigned            fail_count = 0;
  // bumped by a test to make the receiver hold off for a long stretch
  int unsigned            hold_requests = 0;

  trimmed_mean_sensor_calibrator_core #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .sample_i   (sample),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .average_o  (average),
    .value_o    (value),
    .clipped_o  (clipped)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // fold one accepted sample into the batch, close the batch on the tenth
  task automatic fold_sample(input logic [SAMPLE_BITS-1:0] s);
    int unsigned   avg;
    longint        scaled;
    longint        exact;
    batch_result_t r;
    if (batch_fill == 0) begin
      batch_max = s;
      batch_min = s;
      batch_sum = s;
    end else begin
      if (s > batch_max) batch_max = s;
      if (s < batch_min) batch_min = s;
      batch_sum += s;
    end
    batch_fill++;
    if (batch_fill < tmsc_pkg::BATCH_LEN) return;

    // drop one largest and one smallest, even when all ten are equal
    avg = (batch_sum - batch_max - batch_min) >> tmsc_pkg::TRIM_SHIFT;
    batch_fill = 0;
    scaled = avg;
    if (cal_mode == tmsc_pkg::MODE_LOOP) begin
      // below the 4 mA count the loop reads as 4 mA
      if (scaled < cal_zero) scaled = cal_zero;
      exact = cal_gain * scaled - cal_offset;
    end else if (cal_mode == tmsc_pkg::MODE_DOUBLE) begin
      exact = 2 * cal_gain * scaled + cal_low;
    end else begin
      exact = cal_gain * scaled + cal_low;
    end

    // clip to the high limit first, then saturate the bottom of the 32-bit range
    r.clipped = 1'b0;
    if (exact > cal_high) begin
      exact     = cal_high;
      r.clipped = 1'b1;
    end else if (exact < VALUE_MIN) begin
      exact = VALUE_MIN;
    end
    r.average = avg[SAMPLE_BITS-1:0];
    r.value   = exact[31:0];
    batch_results_q.push_back(r);
  endtask

  // one sample beat, held until the block takes it
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
    @(negedge clk_i);
    in_valid <= 1'b1;
    sample   <= s;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    fold_sample(s);
  endtask

  // sender gap, with in_valid low and a random sample on the bus
  task automatic pause_sender(input int unsigned n);
    if (n == 0) return;
    @(negedge clk_i);
    in_valid <= 1'b0;
    sample   <= $urandom_range(0, MAX_SAMPLE);
    repeat (n - 1) @(negedge clk_i);
  endtask

  // stop sending, let every owed result out and the pipe run empty
  task automatic settle_block();
    pause_sender(1);
    while (batch_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // register write, mirrored into the predictor once it has landed
  task automatic write_reg(input logic [tmsc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tmsc_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    case (idx)
      tmsc_pkg::REG_MODE:       cal_mode   = data[1:0];
      tmsc_pkg::REG_ZERO_COUNT: cal_zero   = data[tmsc_pkg::ZERO_W-1:0];
      tmsc_pkg::REG_GAIN:       cal_gain   = longint'($signed(data));
      tmsc_pkg::REG_OFFSET:     cal_offset = longint'($signed(data));
      tmsc_pkg::REG_LOW_LIMIT:  cal_low    = longint'($signed(data));
      tmsc_pkg::REG_HIGH_LIMIT: cal_high   = longint'($signed(data));
      default: ;
    endcase
  endtask

  // Q16.16 word: rails and zero now and then, otherwise a random signed value of random size
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return $signed($urandom) >>> $urandom_range(0, 24);
    endcase
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input sample_style_e style,
                                                          input logic [SAMPLE_BITS-1:0] center);
    int v;
    case (style)
      STYLE_NOISY: begin
        // a steady sensor with a little noise around one level
        v = int'(center) + int'($urandom_range(0, 64)) - 32;
        if (v < 0) v = 0;
        if (v > int'(MAX_SAMPLE)) v = MAX_SAMPLE;
        return v[SAMPLE_BITS-1:0];
      end
      STYLE_RAIL: return $urandom_range(0, 1) ? MAX_SAMPLE[SAMPLE_BITS-1:0] : '0;
      STYLE_FLAT: return center;
      default:    return $urandom_range(0, MAX_SAMPLE);
    endcase
  endfunction

  // every register gets a new value, upper data bits of the narrow ones random
  task automatic load_random_settings();
    logic [tmsc_pkg::CFG_DATA_W-1:0] word;
    write_reg(tmsc_pkg::REG_MODE, $urandom);
    case ($urandom_range(0, 3))
      0:       word = {$urandom_range(0, 1) ? 20'hfffff : 20'h0, 12'h000};
      1:       word = $urandom | 32'h0000_0fff;
      default: word = $urandom;
    endcase
    write_reg(tmsc_pkg::REG_ZERO_COUNT, word);
    write_reg(tmsc_pkg::REG_GAIN, pick_word());
    write_reg(tmsc_pkg::REG_OFFSET, pick_word());
    write_reg(tmsc_pkg::REG_LOW_LIMIT, pick_word());
    write_reg(tmsc_pkg::REG_HIGH_LIMIT, $urandom_range(0, 1) ? 32'h7fff_ffff : pick_word());
  endtask

  // samples in bursts of random length, each burst with its own spread
  task automatic send_stream(input int unsigned n_items);
    int unsigned            left;
    int unsigned            burst;
    sample_style_e          style;
    logic [SAMPLE_BITS-1:0] center;
    left = n_items;
    while (left > 0) begin
      burst  = $urandom_range(1, 30);
      if (burst > left) burst = left;
      style  = sample_style_e'($urandom_range(0, 3));
      center = $urandom_range(0, MAX_SAMPLE);
      repeat (burst) send_sample(pick_sample(style, center));
      left -= burst;
      // some bursts run straight into the next one
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 8));
    end
  endtask

  task automatic test_directed_batches();
    int unsigned i;
    // ten equal full-scale samples under the reset settings
    repeat (tmsc_pkg::BATCH_LEN) send_sample(MAX_SAMPLE);
    settle_block();

    // current loop: average of zero lifted to the 4 mA count, overshoots the high limit
    write_reg(tmsc_pkg::REG_MODE, tmsc_pkg::MODE_LOOP);
    write_reg(tmsc_pkg::REG_ZERO_COUNT, MAX_SAMPLE);
    write_reg(tmsc_pkg::REG_GAIN, 32'h7fff_ffff);
    write_reg(tmsc_pkg::REG_OFFSET, 32'h8000_0000);
    send_sample(0);
    send_sample(MAX_SAMPLE);
    repeat (tmsc_pkg::BATCH_LEN - 2) send_sample(0);
    settle_block();

    // spare mode code with the most negative gain and floor, plus writes to spare indexes
    write_reg(tmsc_pkg::REG_MODE, MODE_SPARE);
    write_reg(tmsc_pkg::REG_GAIN, 32'h8000_0000);
    write_reg(tmsc_pkg::REG_LOW_LIMIT, 32'h8000_0000);
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    for (i = 0; i < tmsc_pkg::BATCH_LEN; i++) begin
      send_sample(i[0] ? MAX_SAMPLE[SAMPLE_BITS-1:0] : '0);
    end
    settle_block();
  endtask

  task automatic test_random_settings();
    repeat (12) begin
      load_random_settings();
      send_stream(100);
      settle_block();
    end
  endtask

  // receiver holds off long enough for the result pipe to fill and stall the input
  task automatic test_output_backpressure();
    load_random_settings();
    hold_requests++;
    repeat (120) send_sample($urandom_range(0, MAX_SAMPLE));
    settle_block();
  endtask

  // result receiver: stall runs of random length and density, long hold-off on request
  initial begin : result_receiver
    int unsigned run_left;
    int unsigned stall_pct;
    int unsigned holds_seen;
    int unsigned hold_left;
    out_stall  = 1'b0;
    run_left   = 0;
    stall_pct  = 0;
    holds_seen = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        // zero density gives stretches with no stall at all
        if (run_left == 0) begin
          run_left  = $urandom_range(1, 40);
          stall_pct = 25 * $urandom_range(0, 3);
        end
        run_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // every accepted result beat against the oldest owed result
  always @(posedge clk_i) begin : result_check
    batch_result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (batch_results_q.size() == 0) begin
        $error("result beat with no batch closed");
        fail_count++;
      end else begin
        want = batch_results_q.pop_front();
        if (average !== want.average) begin
          $error("average: expected %0d, actual %0d", want.average, average);
          fail_count++;
        end
        if (value !== want.value) begin
          $error("value: expected %0d, actual %0d", want.value, value);
          fail_count++;
        end
        if (clipped !== want.clipped) begin
          $error("clipped: expected %0b, actual %0b", want.clipped, clipped);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_ni     = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = tmsc_pkg::REG_MODE;
    cfg_data   = '0;
    in_valid   = 1'b0;
    sample     = '0;
    cal_mode   = tmsc_pkg::CFG_RESET.mode;
    cal_zero   = tmsc_pkg::CFG_RESET.zero_count;
    cal_gain   = longint'(tmsc_pkg::CFG_RESET.gain);
    cal_offset = longint'(tmsc_pkg::CFG_RESET.offset);
    cal_low    = longint'(tmsc_pkg::CFG_RESET.low_limit);
    cal_high   = longint'(tmsc_pkg::CFG_RESET.high_limit);
    batch_fill = 0;
    batch_sum  = 0;
    batch_max  = '0;
    batch_min  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_batches();
    test_random_settings();
    test_output_backpressure();
    settle_block();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hang guard
  initial begin
    #TIMEOUT_NS;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> filelist.f
rtl/tmsc_pkg.sv
rtl/tmsc_stats.sv
rtl/tmsc_calib.sv
rtl/trimmed_mean_sensor_calibrator_core.sv
rtl/tmsc_checker.sv
verif/tb_trimmed_mean_sensor_calibrator_core.sv
